>>> rtl/bre_pkg.sv
// Shared constants and types of the bit range event handler.
package bre_pkg;

	localparam int MAX_BITS    = 1024;
	localparam int ADDR_W      = $clog2(MAX_BITS);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int ID_W        = 64;
	localparam int NODE_W      = 48;
	localparam int BIT_CNT_W   = 11;
	localparam int BIT_INDEX_W = 10;
	localparam int FUNC_W      = 3;
	localparam int KIND_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 64;

	typedef enum logic [FUNC_W-1:0] {
		FN_SET       = 3'd0,
		FN_READ      = 3'd1,
		FN_REPORT    = 3'd2,
		FN_ID_PROD   = 3'd3,
		FN_ID_CONS   = 3'd4,
		FN_ID_GLOBAL = 3'd5
	} func_t;

	localparam logic [KIND_W-1:0] KIND_REPORT     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PROD_VALID = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PROD_INVAL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONS_VALID = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CONS_INVAL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PROD_RANGE = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CONS_RANGE = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE_ID = 2'd2;

endpackage

>>> rtl/bre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bre_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/bit_range_event_handler_top.sv
// Bit range event handler: a bit store mapped onto pairs of event ids.
//
// Input channel (in_valid / in_stall) takes one beat per item: func, event_id,
// bit_index, set_value and dst_node_id. Output channel (out_valid / out_stall)
// gives result beats; last marks the final beat of an item. Items that cause
// no result give no beat. The configuration port (cfg_we, cfg_index, cfg_data)
// writes the base id, the bit count or the own node id, as cfg_index selects.
//
// The bit store sits in a 1024 x 1 RAM. Each item reads its bit in the cycle
// it is accepted and modifies, writes back and loads the output register in
// the work stage (ST_EXEC) once the output register is free; in_stall stays
// high until then, so the next item is accepted only after the last one has
// left the work stage. A global identify addressed to this node (dst_node_id
// zero or the own node id) with a nonzero bit count runs the range encoder
// one bit position per cycle, the last step latching the range, and then
// gives two beats. Result beats are registered in the output register.
// After reset the block clears the store, one entry a cycle; in_stall stays
// high meanwhile. A stalled result waits in the output register, and the block
// holds the next item in its work stage until the register frees up.
module bit_range_event_handler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bre_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bre_pkg::FUNC_W-1:0]      func,
	input  logic [bre_pkg::ID_W-1:0]        event_id,
	input  logic [bre_pkg::BIT_INDEX_W-1:0] bit_index,
	input  logic                            set_value,
	input  logic [bre_pkg::NODE_W-1:0]      dst_node_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            msg_valid,
	output logic [bre_pkg::KIND_W-1:0]      msg_kind,
	output logic [bre_pkg::ID_W-1:0]        msg_event_id,
	output logic                            read_value,
	output logic                            last
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_ENC   = 6'b001000,
		ST_RNG_P = 6'b010000,
		ST_RNG_C = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [bre_pkg::ADDR_W-1:0]    clr_q;
	logic [bre_pkg::ID_W-1:0]      base_id_q;
	logic [bre_pkg::BIT_CNT_W-1:0] bit_count_q;
	logic [bre_pkg::NODE_W-1:0]    own_node_id_q;

	// Work stage, loaded when an item is accepted.
	bre_pkg::func_t             func_s1;
	logic [bre_pkg::ADDR_W-1:0] addr_s1;
	logic                       tgt_s1;
	logic                       hit_s1;
	logic [bre_pkg::ID_W-1:0]   ev_s1;
	logic [bre_pkg::ID_W-1:0]   end_s1;

	// Range encoder.
	logic [bre_pkg::ID_W-1:0] begin_q;
	logic [bre_pkg::ID_W-1:0] shift_q;
	logic                     enc_step;
	logic [bre_pkg::ID_W-1:0] enc_range;

	// Output register.
	logic                       out_valid_q;
	logic                       out_msg_q;
	logic [bre_pkg::KIND_W-1:0] out_kind_q;
	logic [bre_pkg::ID_W-1:0]   out_id_q;
	logic                       out_rd_q;
	logic                       out_last_q;

	logic                        in_acc;
	logic                        slot_free;
	logic [bre_pkg::CNT_W-1:0]   cnt;
	logic [bre_pkg::ID_W-1:0]    ev_diff;
	logic                        ev_hit;
	logic                        idx_hit;
	logic                        glob_ok;
	logic [bre_pkg::ADDR_W-1:0]  rd_addr;
	logic                        ram_we;
	logic [bre_pkg::ADDR_W-1:0]  ram_waddr;
	logic [0:0]                  ram_wdata;
	logic [0:0]                  ram_rdata;

	logic                       ld;
	logic                       ld_msg;
	logic [bre_pkg::KIND_W-1:0] ld_kind;
	logic [bre_pkg::ID_W-1:0]   ld_id;
	logic                       ld_rd;
	logic                       ld_last;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign msg_valid    = out_msg_q;
	assign msg_kind     = out_kind_q;
	assign msg_event_id = out_id_q;
	assign read_value   = out_rd_q;
	assign last         = out_last_q;
	assign slot_free    = !out_valid_q || !out_stall;

	// A count above the store's capacity acts as the capacity.
	assign cnt = (32'(bit_count_q) > 32'(bre_pkg::MAX_BITS)) ?
		bre_pkg::CNT_W'(bre_pkg::MAX_BITS) : bre_pkg::CNT_W'(bit_count_q);

	assign ev_diff = event_id - base_id_q;
	assign ev_hit  = (event_id >= base_id_q)
		&& (ev_diff[bre_pkg::ID_W-1:bre_pkg::ADDR_W+1] == '0)
		&& ({1'b0, ev_diff[bre_pkg::ADDR_W:1]} < cnt);
	assign idx_hit = ({{bre_pkg::CNT_W{1'b0}}, bit_index}
		< {{bre_pkg::BIT_INDEX_W{1'b0}}, cnt});
	assign glob_ok = ((dst_node_id == '0) || (dst_node_id == own_node_id_q))
		&& (cnt != '0);
	assign rd_addr = (func == bre_pkg::FN_SET || func == bre_pkg::FN_READ) ?
		bre_pkg::ADDR_W'(bit_index) : ev_diff[bre_pkg::ADDR_W:1];

	assign enc_step  = (shift_q != '0) && ((begin_q + shift_q) < end_s1);
	// With shift at zero the loop ran past bit 63 and every bit is filled.
	assign enc_range = ((begin_q & shift_q) != '0) ? begin_q :
		(begin_q | (shift_q - bre_pkg::ID_W'(1)));

	bre_ram #(
		.WIDTH(1),
		.DEPTH(bre_pkg::MAX_BITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = tgt_s1;
		ld        = 1'b0;
		ld_msg    = 1'b0;
		ld_kind   = bre_pkg::KIND_REPORT;
		ld_id     = '0;
		ld_rd     = 1'b0;
		ld_last   = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_d = ST_IDLE;
					case (func_s1)
						bre_pkg::FN_SET: begin
							if (hit_s1 && (ram_rdata[0] != tgt_s1)) begin
								ram_we = 1'b1;
								ld     = 1'b1;
								ld_msg = 1'b1;
								ld_id  = base_id_q
									+ bre_pkg::ID_W'({addr_s1, ~tgt_s1});
							end
						end
						bre_pkg::FN_READ: begin
							ld    = 1'b1;
							ld_rd = hit_s1 && ram_rdata[0];
						end
						bre_pkg::FN_REPORT: begin
							ram_we = hit_s1;
						end
						bre_pkg::FN_ID_PROD: begin
							ld      = hit_s1;
							ld_msg  = 1'b1;
							ld_id   = ev_s1;
							ld_kind = (ram_rdata[0] == tgt_s1) ?
								bre_pkg::KIND_PROD_VALID : bre_pkg::KIND_PROD_INVAL;
						end
						bre_pkg::FN_ID_CONS: begin
							ld      = hit_s1;
							ld_msg  = 1'b1;
							ld_id   = ev_s1;
							ld_kind = (ram_rdata[0] == tgt_s1) ?
								bre_pkg::KIND_CONS_VALID : bre_pkg::KIND_CONS_INVAL;
						end
						bre_pkg::FN_ID_GLOBAL: begin
							if (hit_s1) begin
								state_d = ST_ENC;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ENC: begin
				if (!enc_step) begin
					state_d = ST_RNG_P;
				end
			end
			ST_RNG_P: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_msg  = 1'b1;
					ld_kind = bre_pkg::KIND_PROD_RANGE;
					ld_id   = begin_q;
					ld_last = 1'b0;
					state_d = ST_RNG_C;
				end
			end
			ST_RNG_C: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_msg  = 1'b1;
					ld_kind = bre_pkg::KIND_CONS_RANGE;
					ld_id   = begin_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			base_id_q     <= '0;
			bit_count_q   <= bre_pkg::BIT_CNT_W'(1024);
			own_node_id_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + bre_pkg::ADDR_W'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					bre_pkg::REG_BASE_ID:     base_id_q     <= cfg_data;
					bre_pkg::REG_BIT_COUNT:   bit_count_q   <= cfg_data[bre_pkg::BIT_CNT_W-1:0];
					bre_pkg::REG_OWN_NODE_ID: own_node_id_q <= cfg_data[bre_pkg::NODE_W-1:0];
					default: begin
					end
				endcase
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= bre_pkg::func_t'(func);
			addr_s1 <= rd_addr;
			ev_s1   <= event_id;
			// New value of a local set, or the polarity an event id stands for.
			tgt_s1  <= (func == bre_pkg::FN_SET) ? set_value : ~ev_diff[0];
			hit_s1  <= (func == bre_pkg::FN_SET || func == bre_pkg::FN_READ) ? idx_hit :
				((func == bre_pkg::FN_ID_GLOBAL) ? glob_ok : ev_hit);
			end_s1  <= base_id_q + bre_pkg::ID_W'({cnt - bre_pkg::CNT_W'(1), 1'b1});
			begin_q <= base_id_q;
			shift_q <= bre_pkg::ID_W'(1);
		end else if (state_q == ST_ENC) begin
			if (enc_step) begin
				begin_q <= begin_q & ~shift_q;
				shift_q <= {shift_q[bre_pkg::ID_W-2:0], 1'b0};
			end else begin
				begin_q <= enc_range;
			end
		end
		if (ld) begin
			out_msg_q  <= ld_msg;
			out_kind_q <= ld_kind;
			out_id_q   <= ld_id;
			out_rd_q   <= ld_rd;
			out_last_q <= ld_last;
		end
	end

	a_range_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && msg_kind == bre_pkg::KIND_PROD_RANGE) |-> !last)
		else $error("producer range beat marked as last");

	a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid)
		else $error("result beat during store clearing");

	a_enc_shift_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC) |-> $onehot0(shift_q))
		else $error("range encoder shift is not a single bit");

	a_plain_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !msg_valid) |-> (msg_kind == bre_pkg::KIND_REPORT && msg_event_id == '0))
		else $error("beat without message carries kind or id");

endmodule
